// ===== src/usb_line_state_run_decoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// usb line state run decoder assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef USB_LINE_STATE_RUN_DECODER_CORE_ASSERT_SVH
`define USB_LINE_STATE_RUN_DECODER_CORE_ASSERT_SVH

// same-cycle implication, ignored during reset
`define ULSRD_CHECK(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, ignored during reset
`define ULSRD_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, also checked across reset
`define ULSRD_CHECK_RAW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ulsrd_pkg.sv =====
// ----------------------------------------------------------------------------
// ulsrd_pkg
// shared constants, codes and the line state classifier
// ----------------------------------------------------------------------------
package ulsrd_pkg;

   localparam int TIME_BITS_DEFAULT = 40;
   localparam int QUEUE_DEPTH       = 2;
   localparam int CSR_DATA_W        = 40;
   localparam int CSR_INDEX_W       = 1;
   localparam int MV_W              = 13;
   localparam int TICKS_W           = 16;
   localparam int STATE_W           = 2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_MODE       = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSITION_TICKS = 1'd1;

   // speed modes
   localparam logic [1:0] SPD_LOW  = 2'd0;
   localparam logic [1:0] SPD_FULL = 2'd1;
   localparam logic [1:0] SPD_HIGH = 2'd2;

   localparam logic [1:0]            SPEED_RESET      = SPD_FULL;
   localparam logic [CSR_DATA_W-1:0] TRANSITION_RESET = 40'd14;

   // request kinds
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_FLUSH  = 1'b1;

   // line states
   localparam logic [STATE_W-1:0] LS_J   = 2'd0;
   localparam logic [STATE_W-1:0] LS_K   = 2'd1;
   localparam logic [STATE_W-1:0] LS_SE0 = 2'd2;
   localparam logic [STATE_W-1:0] LS_SE1 = 2'd3;

   // thresholds in millivolts
   localparam logic signed [MV_W:0]   DIFF_THR_HS_MV = 14'sd150;
   localparam logic signed [MV_W:0]   DIFF_THR_MV    = 14'sd200;
   localparam logic signed [MV_W-1:0] SE_THR_MV      = 13'sd800;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [STATE_W-1:0] classify_line(
      input logic signed [MV_W-1:0] vp,
      input logic signed [MV_W-1:0] vn,
      input logic [1:0]             speed
   );
      logic signed [MV_W:0]   diff;
      logic signed [MV_W:0]   thr;
      logic                   fast;
      logic [STATE_W-1:0]     st;
      diff = $signed({vp[MV_W-1], vp}) - $signed({vn[MV_W-1], vn});
      thr  = (speed == SPD_HIGH) ? DIFF_THR_HS_MV : DIFF_THR_MV;
      fast = (speed == SPD_FULL) || (speed == SPD_HIGH);
      if (diff > thr || diff < -thr) begin
         if (fast) begin
            st = (diff > 0) ? LS_J : LS_K;
         end else begin
            st = (diff > 0) ? LS_K : LS_J;
         end
      end else if (vp > SE_THR_MV && vn > SE_THR_MV) begin
         st = LS_SE1;
      end else begin
         st = LS_SE0;
      end
      return st;
   endfunction

endpackage

// ===== src/ulsrd_front.sv =====
// ----------------------------------------------------------------------------
// ulsrd_front
// takes request transfers, classifies the line state and queues the item
// ----------------------------------------------------------------------------
module ulsrd_front
   import ulsrd_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_type,
   input  logic signed [MV_W-1:0]          req_v_plus_mv,
   input  logic signed [MV_W-1:0]          req_v_minus_mv,
   input  logic [TIME_BITS-1:0]            req_sample_time,
   input  logic [TICKS_W-1:0]              req_sample_ticks,
   input  logic [1:0]                      speed_mode,
   input  q_status_type                    q_status,
   output logic                            q_push,
   output logic [TIME_BITS+TICKS_W+2:0]    q_item
);

   logic [STATE_W-1:0] line_state;

   assign line_state = classify_line(req_v_plus_mv, req_v_minus_mv, speed_mode);
   assign req_stall  = q_status.full;
   assign q_push     = req_valid && !q_status.full;
   assign q_item     = {req_type, line_state, req_sample_time, req_sample_ticks};

endmodule

// ===== src/ulsrd_queue.sv =====
// ----------------------------------------------------------------------------
// ulsrd_queue
// short queue between the classifier and the run tracker
// ----------------------------------------------------------------------------
module ulsrd_queue
   import ulsrd_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output q_status_type     status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data      = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ===== src/ulsrd_back.sv =====
// ----------------------------------------------------------------------------
// ulsrd_back
// run tracker: merges equal states, absorbs short se0/se1 glitches, emits runs
// ----------------------------------------------------------------------------
module ulsrd_back
   import ulsrd_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  q_status_type                  q_status,
   input  logic [TIME_BITS+TICKS_W+2:0]  q_item,
   output logic                          q_pop,
   input  logic [CSR_DATA_W-1:0]         transition_ticks,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [STATE_W-1:0]            rsp_line_state,
   output logic [TIME_BITS-1:0]          rsp_run_start,
   output logic [TIME_BITS-1:0]          rsp_run_length
);

   localparam int ITEM_W = TIME_BITS + TICKS_W + 3;
   localparam int SUM_W  = TIME_BITS + 1;
   localparam int CMP_W  = (TIME_BITS > CSR_DATA_W) ? TIME_BITS : CSR_DATA_W;

   logic                 item_type;
   logic [STATE_W-1:0]   item_state;
   logic [TIME_BITS-1:0] item_time;
   logic [TICKS_W-1:0]   item_ticks;

   logic                 run_open_ff, run_open_in;
   logic [STATE_W-1:0]   open_state_ff, open_state_in;
   logic [TIME_BITS-1:0] open_start_ff, open_start_in;
   logic [TIME_BITS-1:0] open_length_ff, open_length_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATE_W-1:0]   rsp_line_state_ff;
   logic [TIME_BITS-1:0] rsp_run_start_ff;
   logic [TIME_BITS-1:0] rsp_run_length_ff;

   logic                 out_free;
   logic                 emit;
   logic                 open_is_se;
   logic                 open_short;
   logic [SUM_W-1:0]     sum;
   logic [TIME_BITS-1:0] sat_length;

   assign item_type  = q_item[ITEM_W-1];
   assign item_state = q_item[TICKS_W+TIME_BITS +: STATE_W];
   assign item_time  = q_item[TICKS_W +: TIME_BITS];
   assign item_ticks = q_item[TICKS_W-1:0];

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign q_pop      = !q_status.empty && out_free;

   assign sum        = SUM_W'(open_length_ff) + SUM_W'(item_ticks);
   assign sat_length = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
   assign open_is_se = (open_state_ff == LS_SE0) || (open_state_ff == LS_SE1);
   assign open_short = CMP_W'(open_length_ff) < CMP_W'(transition_ticks);

   always_comb begin
      run_open_in    = run_open_ff;
      open_state_in  = open_state_ff;
      open_start_in  = open_start_ff;
      open_length_in = open_length_ff;
      emit           = 1'b0;
      if (q_pop) begin
         if (item_type == REQ_FLUSH) begin
            if (run_open_ff) begin
               emit        = 1'b1;
               run_open_in = 1'b0;
            end
         end else if (!run_open_ff) begin
            run_open_in    = 1'b1;
            open_state_in  = item_state;
            open_start_in  = item_time;
            open_length_in = TIME_BITS'(item_ticks);
         end else if (item_state == open_state_ff) begin
            open_length_in = sat_length;
         end else if (open_is_se && open_short) begin
            open_state_in  = item_state;
            open_length_in = sat_length;
         end else begin
            emit           = 1'b1;
            open_state_in  = item_state;
            open_start_in  = item_time;
            open_length_in = TIME_BITS'(item_ticks);
         end
      end
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff    <= 1'b0;
         open_state_ff  <= LS_J;
         open_start_ff  <= '0;
         open_length_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         run_open_ff    <= run_open_in;
         open_state_ff  <= open_state_in;
         open_start_ff  <= open_start_in;
         open_length_ff <= open_length_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_line_state_ff <= open_state_ff;
         rsp_run_start_ff  <= open_start_ff;
         rsp_run_length_ff <= open_length_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_state = rsp_line_state_ff;
   assign rsp_run_start  = rsp_run_start_ff;
   assign rsp_run_length = rsp_run_length_ff;

endmodule

// ===== src/usb_line_state_run_decoder_core.sv =====
// ----------------------------------------------------------------------------
// usb_line_state_run_decoder_core
// turns d+/d- voltage samples into emitted line state runs
// ----------------------------------------------------------------------------
// Takes one sample or flush transfer per clock unless req_stall (queue full)
// is high. A sample is classified as J, K, SE0 or SE1 in the cycle it is
// taken and queued; the run tracker pops one queued item per cycle while the
// result register is free or being taken, so the result for the request that
// closed the run passes the queue slot and then the result register before it
// shows on rsp_. The run tracker updates the open run with one saturating add
// and one compare against transition_ticks; a two-entry queue and the result
// register let each side stall on its own. No clearing pass follows reset.
module usb_line_state_run_decoder_core
   import ulsrd_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_type,
   input  logic signed [MV_W-1:0] req_v_plus_mv,
   input  logic signed [MV_W-1:0] req_v_minus_mv,
   input  logic [TIME_BITS-1:0]   req_sample_time,
   input  logic [TICKS_W-1:0]     req_sample_ticks,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATE_W-1:0]     rsp_line_state,
   output logic [TIME_BITS-1:0]   rsp_run_start,
   output logic [TIME_BITS-1:0]   rsp_run_length
);

   localparam int ITEM_W = TIME_BITS + TICKS_W + 3;

   logic [1:0]            speed_mode_ff, speed_mode_in;
   logic [CSR_DATA_W-1:0] transition_ticks_ff, transition_ticks_in;

   q_status_type          q_status;
   logic                  q_push;
   logic                  q_pop;
   logic [ITEM_W-1:0]     q_wr_item;
   logic [ITEM_W-1:0]     q_rd_item;

   always_comb begin
      speed_mode_in       = speed_mode_ff;
      transition_ticks_in = transition_ticks_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SPEED_MODE:       speed_mode_in       = csr_wr_data[1:0];
            CSR_TRANSITION_TICKS: transition_ticks_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_mode_ff       <= SPEED_RESET;
         transition_ticks_ff <= TRANSITION_RESET;
      end else begin
         speed_mode_ff       <= speed_mode_in;
         transition_ticks_ff <= transition_ticks_in;
      end
   end

   ulsrd_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_v_plus_mv    (req_v_plus_mv),
      .req_v_minus_mv   (req_v_minus_mv),
      .req_sample_time  (req_sample_time),
      .req_sample_ticks (req_sample_ticks),
      .speed_mode       (speed_mode_ff),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_item           (q_wr_item)
   );

   ulsrd_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_item),
      .pop     (q_pop),
      .rd_data (q_rd_item),
      .status  (q_status)
   );

   ulsrd_back #(
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_item           (q_rd_item),
      .q_pop            (q_pop),
      .transition_ticks (transition_ticks_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_state   (rsp_line_state),
      .rsp_run_start    (rsp_run_start),
      .rsp_run_length   (rsp_run_length)
   );

endmodule

// ===== src/ulsrd_checker.sv =====
// ----------------------------------------------------------------------------
// ulsrd_checker
// port-level checks on the run decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "usb_line_state_run_decoder_core_assert.svh"

module ulsrd_checker
   import ulsrd_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [STATE_W-1:0]   rsp_line_state,
   input logic [TIME_BITS-1:0] rsp_run_start,
   input logic [TIME_BITS-1:0] rsp_run_length
);

   // reset leaves no result pending and the queue open for transfers
   `ULSRD_CHECK_RAW(a_reset_idle, reset, !rsp_valid && !req_stall, "not idle after reset")

   // a stalled result is neither dropped nor changed
   `ULSRD_CHECK_NEXT(a_rsp_hold_valid, rsp_valid && rsp_stall, rsp_valid, "result dropped")
   `ULSRD_CHECK_NEXT(a_rsp_hold_data, rsp_valid && rsp_stall, $stable(rsp_line_state) && $stable(rsp_run_start) && $stable(rsp_run_length), "result changed")

   // the result register alone cannot back up the input side
   `ULSRD_CHECK(a_no_stall_when_drained, $past(!req_stall) && !rsp_valid && $past(!rsp_valid), !req_stall, "input stalled with empty pipeline")

endmodule

bind usb_line_state_run_decoder_core ulsrd_checker #(
   .TIME_BITS (TIME_BITS)
) u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_line_state (rsp_line_state),
   .rsp_run_start  (rsp_run_start),
   .rsp_run_length (rsp_run_length)
);

// ===== tb/sv/usb_line_run_checker.sv =====
// ----------------------------------------------------------------------------
// usb_line_run_checker
// watches the request and result channels of the line state run decoder,
// tracks the open run and the register settings, and compares every result
// transfer field by field with the oldest closed run still awaited
// ----------------------------------------------------------------------------
module usb_line_run_checker
   import ulsrd_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic                   req_type,
   input  logic signed [MV_W-1:0] req_v_plus_mv,
   input  logic signed [MV_W-1:0] req_v_minus_mv,
   input  logic [TIME_BITS-1:0]   req_sample_time,
   input  logic [TICKS_W-1:0]     req_sample_ticks,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [STATE_W-1:0]     rsp_line_state,
   input  logic [TIME_BITS-1:0]   rsp_run_start,
   input  logic [TIME_BITS-1:0]   rsp_run_length,
   output int                     failures,
   output int                     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HS_DIFF_MV = 150;
   localparam int FS_DIFF_MV = 200;
   localparam int SE_MV      = 800;
   localparam int SUM_W      = TIME_BITS + 1;

   typedef struct packed {
      logic [STATE_W-1:0]   line_state;
      logic [TIME_BITS-1:0] run_start;
      logic [TIME_BITS-1:0] run_length;
   } line_run_type;

   logic                  run_open;
   line_run_type          open_run;
   logic [1:0]            speed_cfg;
   logic [CSR_DATA_W-1:0] transition_cfg;
   line_run_type          closed_runs_q[$];
   int                    mismatches = 0;

   function automatic logic [STATE_W-1:0] line_state_of(
      input logic signed [MV_W-1:0] vp,
      input logic signed [MV_W-1:0] vn,
      input logic [1:0]             speed
   );
      int   diff;
      int   mag;
      int   thr;
      logic fast;
      diff = int'(vp) - int'(vn);
      mag  = (diff < 0) ? -diff : diff;
      thr  = (speed == SPD_HIGH) ? HS_DIFF_MV : FS_DIFF_MV;
      fast = (speed == SPD_FULL) || (speed == SPD_HIGH);
      if (mag > thr) begin
         // low speed and the reserved speed mode swap j and k
         return ((diff > 0) == fast) ? LS_J : LS_K;
      end
      if (int'(vp) > SE_MV && int'(vn) > SE_MV) begin
         return LS_SE1;
      end
      return LS_SE0;
   endfunction

   function automatic logic [TIME_BITS-1:0] grow(
      input logic [TIME_BITS-1:0] len,
      input logic [TICKS_W-1:0]   ticks
   );
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(len) + SUM_W'(ticks);
      return sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
   endfunction

   task automatic advance_open_run();
      logic [STATE_W-1:0] st;
      if (req_type == REQ_FLUSH) begin
         if (run_open) begin
            closed_runs_q.insert(closed_runs_q.size(), open_run);
         end
         run_open = 1'b0;
         return;
      end
      st = line_state_of(req_v_plus_mv, req_v_minus_mv, speed_cfg);
      if (run_open && open_run.line_state == st) begin
         open_run.run_length = grow(open_run.run_length, req_sample_ticks);
      end else if (run_open && (open_run.line_state == LS_SE0 || open_run.line_state == LS_SE1)
                   && open_run.run_length < transition_cfg) begin
         // short single-ended stretch is part of the transition
         open_run.line_state = st;
         open_run.run_length = grow(open_run.run_length, req_sample_ticks);
      end else begin
         if (run_open) begin
            closed_runs_q.insert(closed_runs_q.size(), open_run);
         end
         run_open            = 1'b1;
         open_run.line_state = st;
         open_run.run_start  = req_sample_time;
         open_run.run_length = TIME_BITS'(req_sample_ticks);
      end
   endtask

   task automatic check_result();
      line_run_type want;
      if (closed_runs_q.size() == 0) begin
         $error("unexpected result transfer: line_state %0d run_start %0h run_length %0h",
                rsp_line_state, rsp_run_start, rsp_run_length);
         mismatches++;
         return;
      end
      want = closed_runs_q.pop_front();
      if (rsp_line_state !== want.line_state) begin
         $error("line_state mismatch: expected %0d, actual %0d",
                want.line_state, rsp_line_state);
         mismatches++;
      end
      if (rsp_run_start !== want.run_start) begin
         $error("run_start mismatch: expected %0h, actual %0h", want.run_start, rsp_run_start);
         mismatches++;
      end
      if (rsp_run_length !== want.run_length) begin
         $error("run_length mismatch: expected %0h, actual %0h",
                want.run_length, rsp_run_length);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         run_open       = 1'b0;
         open_run       = '0;
         speed_cfg      = SPEED_RESET;
         transition_cfg = TRANSITION_RESET;
         closed_runs_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SPEED_MODE:       speed_cfg = csr_wr_data[1:0];
               CSR_TRANSITION_TICKS: transition_cfg = csr_wr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            check_result();
         end
         if (req_valid && !req_stall) begin
            advance_open_run();
         end
      end
      failures    <= mismatches;
      outstanding <= closed_runs_q.size();
   end

endmodule

// ===== tb/sv/tb_usb_line_state_run_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tb_usb_line_state_run_decoder_core
// drives sample and flush transfers into the line state run decoder under
// several speed and transition settings: a directed pass over thresholds,
// polarity, transition glitches and flushes, then random line activity with
// noise, random stalls on both sides and one long result hold-off
// ----------------------------------------------------------------------------
module tb_usb_line_state_run_decoder_core;
   timeunit 1ns;
   timeprecision 1ps;

   import ulsrd_pkg::*;

   localparam int         TIME_BITS      = TIME_BITS_DEFAULT;
   localparam int         DRAIN_CYCLES   = 8;
   localparam int         HOLD_CYCLES    = 300;
   localparam int         BURST_ITEMS    = 40;
   localparam int         BLOCK_ITEMS    = 300;
   localparam int         WATCHDOG_LIMIT = 3000;
   localparam logic [1:0] SPEED_RESERVED = 2'd3;

   typedef enum {LVL_DIFF_POS, LVL_DIFF_NEG, LVL_SE0, LVL_SE1, LVL_NOISE} level_kind_type;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   csr_wr_en        = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data      = '0;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic                   req_type         = REQ_SAMPLE;
   logic signed [MV_W-1:0] req_v_plus_mv    = '0;
   logic signed [MV_W-1:0] req_v_minus_mv   = '0;
   logic [TIME_BITS-1:0]   req_sample_time  = '0;
   logic [TICKS_W-1:0]     req_sample_ticks = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic [STATE_W-1:0]     rsp_line_state;
   logic [TIME_BITS-1:0]   rsp_run_start;
   logic [TIME_BITS-1:0]   rsp_run_length;

   int                     failures;
   int                     outstanding;
   int                     req_idle_pct  = 0;
   int                     rsp_idle_pct  = 0;
   int                     hold_requests = 0;
   int                     holds_served  = 0;
   int                     hold_left     = 0;
   int                     quiet_cycles  = 0;
   int                     items_sent    = 0;
   logic [TIME_BITS-1:0]   line_time     = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   usb_line_state_run_decoder_core #(.TIME_BITS(TIME_BITS)) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_v_plus_mv    (req_v_plus_mv),
      .req_v_minus_mv   (req_v_minus_mv),
      .req_sample_time  (req_sample_time),
      .req_sample_ticks (req_sample_ticks),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_state   (rsp_line_state),
      .rsp_run_start    (rsp_run_start),
      .rsp_run_length   (rsp_run_length)
   );

   usb_line_run_checker #(.TIME_BITS(TIME_BITS)) run_check (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_v_plus_mv    (req_v_plus_mv),
      .req_v_minus_mv   (req_v_minus_mv),
      .req_sample_time  (req_sample_time),
      .req_sample_ticks (req_sample_ticks),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_state   (rsp_line_state),
      .rsp_run_start    (rsp_run_start),
      .rsp_run_length   (rsp_run_length),
      .failures         (failures),
      .outstanding      (outstanding)
   );

   // result side: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_requests != holds_served) begin
         holds_served++;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [TIME_BITS-1:0] rand_time();
      return TIME_BITS'({$urandom, $urandom});
   endfunction

   task automatic put_transfer(
      input logic                   kind,
      input logic signed [MV_W-1:0] vp,
      input logic signed [MV_W-1:0] vn,
      input logic [TIME_BITS-1:0]   t,
      input logic [TICKS_W-1:0]     ticks
   );
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_v_plus_mv    <= vp;
      req_v_minus_mv   <= vn;
      req_sample_time  <= t;
      req_sample_ticks <= ticks;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_sample(
      input logic signed [MV_W-1:0] vp,
      input logic signed [MV_W-1:0] vn,
      input logic [TICKS_W-1:0]     ticks
   );
      put_transfer(REQ_SAMPLE, vp, vn, line_time, ticks);
      line_time += ticks;
   endtask

   // flush ignores the payload, so it carries noise
   task automatic send_flush();
      put_transfer(REQ_FLUSH, MV_W'($urandom), MV_W'($urandom), rand_time(),
                   TICKS_W'($urandom));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [1:0] speed, input logic [CSR_DATA_W-1:0] ticks);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_SPEED_MODE;
      csr_wr_data <= CSR_DATA_W'(speed);
      @(posedge clock);
      csr_index   <= CSR_TRANSITION_TICKS;
      csr_wr_data <= ticks;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic pick_levels(
      input  level_kind_type         kind,
      output logic signed [MV_W-1:0] vp,
      output logic signed [MV_W-1:0] vn
   );
      int base;
      int mag;
      case (kind)
         LVL_DIFF_POS, LVL_DIFF_NEG: begin
            // some magnitudes sit right at the differential thresholds
            mag  = ($urandom_range(9) == 0) ? 145 + int'($urandom_range(60))
                                            : 150 + int'($urandom_range(1200));
            base = int'($urandom_range(2800)) - 1200;
            if (kind == LVL_DIFF_POS) begin
               vp = MV_W'(base + mag);
               vn = MV_W'(base);
            end else begin
               vp = MV_W'(base);
               vn = MV_W'(base + mag);
            end
         end
         LVL_SE0: begin
            base = int'($urandom_range(900)) - 100;
            vp   = MV_W'(base);
            vn   = MV_W'(base + int'($urandom_range(300)) - 150);
         end
         LVL_SE1: begin
            base = 951 + int'($urandom_range(2000));
            vp   = MV_W'(base);
            vn   = MV_W'(base + int'($urandom_range(300)) - 150);
         end
         default: begin
            vp = MV_W'($urandom);
            vn = MV_W'($urandom);
         end
      endcase
   endtask

   task automatic send_segment();
      level_kind_type         kind;
      int                     roll;
      int                     count;
      logic signed [MV_W-1:0] vp;
      logic signed [MV_W-1:0] vn;
      logic [TICKS_W-1:0]     ticks;
      roll = $urandom_range(99);
      if (roll < 5) begin
         send_flush();
         return;
      end
      if (roll < 13) begin
         kind = LVL_NOISE;
      end else if (roll < 48) begin
         kind = LVL_DIFF_POS;
      end else if (roll < 83) begin
         kind = LVL_DIFF_NEG;
      end else if (roll < 95) begin
         kind = LVL_SE0;
      end else begin
         kind = LVL_SE1;
      end
      count = (kind == LVL_SE0 || kind == LVL_SE1) ? $urandom_range(1, 2) : $urandom_range(1, 5);
      repeat (count) begin
         pick_levels(kind, vp, vn);
         roll = $urandom_range(19);
         if (roll == 0) begin
            ticks = '0;
         end else if (roll < 3) begin
            ticks = TICKS_W'($urandom);
         end else if (kind == LVL_SE0 || kind == LVL_SE1) begin
            ticks = TICKS_W'($urandom_range(1, 12));
         end else begin
            ticks = TICKS_W'($urandom_range(1, 24));
         end
         if (kind == LVL_NOISE && $urandom_range(1) == 0) begin
            line_time = rand_time();
         end
         send_sample(vp, vn, ticks);
      end
   endtask

   // hold the result side off while transfers keep coming, alternating j and k
   task automatic overfill_burst();
      int saved_pct;
      saved_pct     = req_idle_pct;
      req_idle_pct  = 0;
      hold_requests <= hold_requests + 1;
      for (int n = 0; n < BURST_ITEMS; n++) begin
         send_sample((n % 2) ? -600 : 600, 0, 3);
      end
      req_idle_pct = saved_pct;
   endtask

   initial begin
      int start;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_config(SPD_FULL, TRANSITION_RESET);

      // full speed thresholds, polarity, glitches and flushes
      send_flush();
      send_sample(4095, -4096, 16'hFFFF);
      send_sample(300, 0, 0);
      line_time = '1;
      send_sample(-4096, 4095, 7);
      send_sample(0, 0, 3);
      send_sample(801, 801, 5);
      send_sample(201, 0, 2);
      send_sample(200, 0, 4);
      send_sample(800, 800, 20);
      send_sample(0, 201, 1);
      send_flush();
      send_flush();
      settle();
      write_config(SPD_LOW, '0);
      send_sample(201, 0, 5);
      send_sample(0, 0, 1);
      send_sample(0, 201, 1);
      send_flush();
      settle();
      write_config(SPD_HIGH, '1);
      send_sample(151, 0, 5);
      send_sample(150, 0, 9);
      send_sample(900, 900, 16'hFFFF);
      send_sample(-151, 0, 3);
      send_flush();
      settle();
      write_config(SPEED_RESERVED, TRANSITION_RESET);
      send_sample(201, 0, 4);
      send_sample(0, 200, 4);
      send_sample(-4096, -4096, 1);
      send_flush();

      for (int blk = 0; blk < 6; blk++) begin
         settle();
         case (blk)
            0:       write_config(SPD_FULL, TRANSITION_RESET);
            1:       write_config(SPD_LOW, CSR_DATA_W'($urandom_range(5, 40)));
            2:       write_config(SPD_HIGH, '0);
            3:       write_config(SPEED_RESERVED, CSR_DATA_W'({$urandom, $urandom}));
            4:       write_config(SPD_FULL, '1);
            default: write_config(2'($urandom_range(3)), TRANSITION_RESET);
         endcase
         req_idle_pct = (blk < 2) ? 38 : (blk < 4) ? 61 : 0;
         rsp_idle_pct <= (blk < 2) ? 61 : (blk < 4) ? 38 : 0;
         if (blk == 0) begin
            overfill_burst();
         end
         start = items_sent;
         while (items_sent - start < BLOCK_ITEMS) send_segment();
      end

      settle();
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
